>>> rtl/core/tkd_pkg.sv
// Shared types and constants for the tree kinship distance core.
// Holds field widths, command codes, the controller state type and mark-tag sizing.
// No dependencies.
package tkd_pkg;

  // Widths of the transaction fields.
  localparam int NODE_W = 7;
  localparam int DIST_W = 9;

  // Default size of the node table.
  localparam int NODES_DEF = 128;

  // Distances saturate here; unrelated nodes report all ones (-1).
  localparam int DIST_MAX = 254;
  localparam logic signed [DIST_W-1:0] DIST_NONE = '1;

  // Width of the query tag stored with each ancestor mark.
  localparam int EPOCH_W = 8;

  // Command codes of an input transaction.
  typedef enum logic {
    CMD_LINK  = 1'b0,
    CMD_QUERY = 1'b1
  } tkd_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_WALK
  } tkd_state_t;

endpackage

>>> rtl/core/tkd_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// A read of the address being written in the same cycle returns the new data.
// Depends on nothing.
module tkd_ram #(
  parameter int DW    = 8,
  parameter int AW    = 7,
  parameter int DEPTH = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read with write-first forwarding.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/tree_kinship_distance_core.sv
// Top level of the tree kinship distance core: controller plus parent and mark memories.
// Depends on tkd_pkg and tkd_ram.
//
// Usage: a transaction is taken when start is high and busy is low. A link transaction
// (in_cmd = link) sets the parent of in_node_a to in_node_b; it gives no result and
// leaves busy low. A query transaction gives one result on out_distance,
// marked by a one-cycle out_valid strobe: the edge count between the two nodes through
// their lowest common ancestor, saturated at 254, or -1 if they are unrelated.
// A query naming node 0 or a node outside the table reports -1 in the next cycle
// without raising busy. Otherwise busy stays high while the controller marks the
// ancestor chain of in_node_a and then climbs the chain of in_node_b; the strobe is
// high in the cycle in which busy reads low again, unless a clearing pass starts.
// Each chain step is one read of the parent and mark memories.
// Marks carry a query tag instead of being cleared per query. After reset, and after
// every 255th well-formed query, a clearing pass holds busy high; the pass after
// reset also clears the parent table. The receiver cannot stall: each result is
// present for exactly one cycle.
module tree_kinship_distance_core
  import tkd_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic [NODE_W-1:0]        in_node_a,
  input  logic [NODE_W-1:0]        in_node_b,
  output logic                     out_valid,
  output logic signed [DIST_W-1:0] out_distance
);

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int MW = EPOCH_W + AW;
  localparam int SW = CW + 1;

  // Controller registers.
  tkd_state_t           state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 clr_par_r, clr_par_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic [NODE_W-1:0]    b_r, b_nxt;
  logic                 first_r, first_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        db_r, db_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DIST_W-1:0] out_distance_r, out_distance_nxt;

  // Memory ports.
  logic                 par_we;
  logic [AW-1:0]        par_waddr;
  logic [NODE_W-1:0]    par_wdata;
  logic [NODE_W-1:0]    par_rdata;
  logic                 mark_we;
  logic [AW-1:0]        mark_waddr;
  logic [MW-1:0]        mark_wdata;
  logic [MW-1:0]        mark_rdata;
  logic [NODE_W-1:0]    rd_node;

  // Decode of the current transaction and of the memory read data.
  logic                 accept;
  logic                 a_ok;
  logic                 b_ok;
  logic                 query_ok;
  logic                 p_zero;
  logic                 mk_hit;
  logic [AW-1:0]        mk_depth;
  logic                 mark_seen;
  logic                 mark_done;
  logic                 walk_limit;
  logic                 walk_done;
  logic [SW-1:0]        dist_sum;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign a_ok       = (in_node_a != '0) && (int'(in_node_a) < NODES);
  assign b_ok       = int'(in_node_b) < NODES;
  assign query_ok   = a_ok && b_ok && (in_node_b != '0);
  assign p_zero     = (par_rdata == '0);
  assign mk_hit     = (mark_rdata[MW-1 -: EPOCH_W] == epoch_r);
  assign mk_depth   = mark_rdata[AW-1:0];
  assign mark_seen  = !first_r && mk_hit;
  assign mark_done  = mark_seen || p_zero;
  assign walk_limit = (db_r == CW'(NODES));
  assign walk_done  = mk_hit || p_zero || walk_limit;
  assign dist_sum   = SW'(mk_depth) + SW'(db_r);

  // Parent table: one node number per entry, 0 for no parent.
  tkd_ram #(
    .DW    (NODE_W),
    .AW    (AW),
    .DEPTH (NODES)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (AW'(rd_node)),
    .rdata (par_rdata)
  );

  // Ancestor marks: query tag and depth below the first queried node.
  tkd_ram #(
    .DW    (MW),
    .AW    (AW),
    .DEPTH (NODES)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (AW'(rd_node)),
    .rdata (mark_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY) && query_ok) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (mark_done) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = (epoch_r == '1) ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Memory controls and datapath register updates.
  always_comb begin
    par_we           = 1'b0;
    par_waddr        = AW'(in_node_a);
    par_wdata        = in_node_b;
    mark_we          = 1'b0;
    mark_waddr       = AW'(cur_r);
    mark_wdata       = {epoch_r, k_r};
    rd_node          = cur_r;
    clr_addr_nxt     = clr_addr_r;
    clr_par_nxt      = clr_par_r;
    epoch_nxt        = epoch_r;
    cur_nxt          = cur_r;
    b_nxt            = b_r;
    first_nxt        = first_r;
    k_nxt            = k_r;
    db_nxt           = db_r;
    out_valid_nxt    = 1'b0;
    out_distance_nxt = out_distance_r;
    case (state_r)
      // Sweep the marks, and after reset the parent table, one entry a cycle.
      S_CLEAR: begin
        mark_we      = 1'b1;
        mark_waddr   = clr_addr_r;
        mark_wdata   = '0;
        par_we       = clr_par_r;
        par_waddr    = clr_addr_r;
        par_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NODES - 1)) begin
          clr_addr_nxt = '0;
          clr_par_nxt  = 1'b0;
        end
      end
      // Take a transaction: write a link, reject a bad query, or start the walks.
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LINK) begin
            par_we = a_ok && b_ok;
          end else if (query_ok) begin
            rd_node   = in_node_a;
            cur_nxt   = in_node_a;
            b_nxt     = in_node_b;
            first_nxt = 1'b1;
            k_nxt     = '0;
          end else begin
            out_valid_nxt    = 1'b1;
            out_distance_nxt = DIST_NONE;
          end
        end
      end
      // Mark the current node with its depth, then step to its parent.
      // A node already marked means the chain loops and marking is complete.
      S_MARK: begin
        mark_we = !mark_seen;
        if (mark_done) begin
          rd_node = b_r;
          cur_nxt = b_r;
          db_nxt  = '0;
        end else begin
          rd_node   = par_rdata;
          cur_nxt   = par_rdata;
          k_nxt     = k_r + AW'(1);
          first_nxt = 1'b0;
        end
      end
      // Climb from the second node until a marked node, a root or the step limit.
      S_WALK: begin
        if (mk_hit) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = (int'(dist_sum) > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                         : DIST_W'(dist_sum);
        end else if (p_zero || walk_limit) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = DIST_NONE;
        end else begin
          rd_node = par_rdata;
          cur_nxt = par_rdata;
          db_nxt  = db_r + CW'(1);
        end
        if (walk_done) begin
          epoch_nxt = (epoch_r == '1) ? EPOCH_W'(1) : epoch_r + EPOCH_W'(1);
        end
      end
      default: begin
        clr_addr_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_par_r   <= 1'b1;
      epoch_r     <= EPOCH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_par_r   <= clr_par_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    b_r            <= b_nxt;
    first_r        <= first_nxt;
    k_r            <= k_nxt;
    db_r           <= db_nxt;
    out_distance_r <= out_distance_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

`ifndef NO_ASSERTIONS
  // A link transaction never makes the block busy.
  a_link_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_LINK)) |=> !busy)
    else $error("link transaction raised busy");

  // A well-formed query starts the walks and gives no immediate result.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_QUERY) && query_ok) |=> (busy && !out_valid))
    else $error("query did not start the ancestor walks");

  // The walks only read the parent table.
  a_walk_no_par_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MARK) || (state_r == S_WALK)) |-> !par_we)
    else $error("parent table written during a query");

  // Tag zero is reserved for cleared marks.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("query tag reached the cleared value");
`endif

endmodule

>>> tb/tree_kinship_distance_core_test.sv
// Self-checking testbench for tree_kinship_distance_core: link and distance-query transactions.
// A clocked driver feeds planned transactions, an in-bench predictor tracks the parent table,
// and a monitor checks each result strobe. Depends on tkd_pkg and the core.
module tree_kinship_distance_core_test;
  import tkd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int TABLE_N      = NODES_DEF;
  localparam int ITEMS        = 1500;
  localparam int TAIL_ITEMS   = 120;
  localparam int LIMIT_CYCLES = 2_000_000;

  // Tree shapes used when planning a well-formed forest.
  localparam int SHAPE_BUSHY = 0;
  localparam int SHAPE_CHAIN = 1;
  localparam int SHAPE_FORK  = 2;

  // One input transaction; hold makes the sender wait until all results are in.
  typedef struct {
    tkd_cmd_t          cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    bit                hold;
  } tkd_item_t;

  // One predicted query answer.
  typedef struct {
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [DIST_W-1:0] distance;
  } tkd_answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_cmd = 1'b0;
  logic [NODE_W-1:0]        in_node_a = '0;
  logic [NODE_W-1:0]        in_node_b = '0;
  logic                     out_valid;
  logic signed [DIST_W-1:0] out_distance;

  tkd_item_t         pending_items[$];
  tkd_item_t         on_bus;
  tkd_answer_t       expected_dist[$];
  logic [NODE_W-1:0] parent_of [TABLE_N];

  int n_planned = 0;
  int n_accepted = 0;
  int n_links = 0;
  int n_queries = 0;
  int n_results = 0;
  int n_unrelated = 0;
  int n_holds = 0;
  int max_dist = 0;
  int n_errors = 0;
  int gap_left = 0;
  int idle_pct = 20;

  tree_kinship_distance_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_distance (out_distance)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic flag_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Distance through the lowest common ancestor, from the predicted parent table.
  function automatic logic signed [DIST_W-1:0] kinship_distance(logic [NODE_W-1:0] a,
                                                                logic [NODE_W-1:0] b);
    bit          on_a_chain [TABLE_N];
    int unsigned x, p, meet, up_a, up_b;
    bit          met;
    met = 1'b0;
    meet = 0;
    up_a = 0;
    up_b = 0;
    if (a == 0 || b == 0 || int'(a) >= TABLE_N || int'(b) >= TABLE_N) return DIST_NONE;
    foreach (on_a_chain[i]) on_a_chain[i] = 1'b0;
    // Mark the first node and its ancestors; a looping chain stops after TABLE_N steps.
    x = a;
    on_a_chain[x] = 1'b1;
    for (int i = 0; i < TABLE_N; i++) begin
      p = parent_of[x];
      if (p == 0) break;
      x = p;
      on_a_chain[x] = 1'b1;
    end
    // Climb from the second node until a marked node is met.
    x = b;
    for (int i = 0; i <= TABLE_N; i++) begin
      if (on_a_chain[x]) begin
        meet = x;
        met = 1'b1;
        break;
      end
      p = parent_of[x];
      if (p == 0) break;
      x = p;
      up_b++;
    end
    if (!met) return DIST_NONE;
    // Depth of the first node below the meeting point.
    x = a;
    while (x != meet && up_a < TABLE_N) begin
      x = parent_of[x];
      up_a++;
    end
    up_a += up_b;
    if (up_a > DIST_MAX) up_a = DIST_MAX;
    return up_a[DIST_W-1:0];
  endfunction

  // Appends one transaction to the plan; links of node zero do nothing and are not counted.
  task automatic plan_item(tkd_cmd_t cmd, int a, int b, bit hold = 1'b0);
    tkd_item_t it;
    it.cmd = cmd;
    it.node_a = a[NODE_W-1:0];
    it.node_b = b[NODE_W-1:0];
    it.hold = hold;
    pending_items.push_back(it);
    if (!(cmd == CMD_LINK && it.node_a == 0)) n_planned++;
  endtask

  // Builds a forest over a random node set, optionally tangles it, then queries it.
  task automatic plan_forest(int size, int shape, bit tangle);
    int pool [TABLE_N-1];
    int j, tmp, up, x, y;
    for (int i = 0; i < TABLE_N - 1; i++) pool[i] = i + 1;
    for (int i = 0; i < size; i++) begin
      j = $urandom_range(TABLE_N - 2, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int i = 0; i < size; i++) begin
      case (shape)
        SHAPE_CHAIN: begin
          up = (i == 0) ? 0 : pool[i-1];
        end
        SHAPE_FORK: begin
          up = (i == 0) ? 0 : (i < 3) ? pool[0] : pool[i-2];
        end
        default: begin
          up = (i == 0 || $urandom_range(0, 9) == 0) ? 0 : pool[$urandom_range(0, i - 1)];
        end
      endcase
      plan_item(CMD_LINK, pool[i], up);
    end
    // Extra links inside the set may close a loop.
    if (tangle) begin
      repeat ($urandom_range(1, 2)) begin
        plan_item(CMD_LINK, pool[$urandom_range(0, size - 1)], pool[$urandom_range(0, size - 1)]);
      end
    end
    repeat ($urandom_range(3, 12)) begin
      x = pool[$urandom_range(0, size - 1)];
      y = pool[$urandom_range(0, size - 1)];
      case ($urandom_range(0, 9))
        0: y = x;
        1: y = $urandom_range(0, TABLE_N - 1);
        2: x = $urandom_range(0, TABLE_N - 1);
        3: begin
          x = pool[size-1];
          y = pool[0];
        end
        4: begin
          x = pool[size-1];
          y = pool[size-2];
        end
        default: ;
      endcase
      plan_item(CMD_QUERY, x, y);
    end
  endtask

  // Driver: presents planned transactions and updates the predictor on each handshake.
  always @(posedge clk) begin : drive_proc
    logic start_next;
    start_next = start;
    if (rst_n) begin
      if (start && !busy) begin
        if (on_bus.cmd == CMD_LINK) begin
          n_links++;
          if (on_bus.node_a != 0 && int'(on_bus.node_a) < TABLE_N &&
              int'(on_bus.node_b) < TABLE_N) begin
            parent_of[on_bus.node_a] = on_bus.node_b;
          end
        end else begin
          n_queries++;
          expected_dist.push_back('{on_bus.node_a, on_bus.node_b,
                                    kinship_distance(on_bus.node_a, on_bus.node_b)});
        end
        n_accepted++;
        start_next = 1'b0;
        // Idle density changes now and then, so calm and busy stretches alternate.
        if (n_accepted % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
          endcase
        end
        if (pending_items.size() > TAIL_ITEMS && $urandom_range(1, 100) <= idle_pct) begin
          gap_left = $urandom_range(1, 16);
        end
      end
      if (!start_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_dist.size() != 0)) begin
          on_bus = pending_items.pop_front();
          if (on_bus.hold) n_holds++;
          in_cmd <= on_bus.cmd;
          in_node_a <= on_bus.node_a;
          in_node_b <= on_bus.node_b;
          start_next = 1'b1;
        end
      end
    end
    start <= start_next;
  end

  // Monitor: sampled mid-cycle, while each result strobe is stable.
  always @(negedge clk) begin : check_proc
    tkd_answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_dist.size() == 0) begin
        flag_mismatch($sformatf("distance %0d arrived with no query outstanding",
                                out_distance));
      end else begin
        want = expected_dist.pop_front();
        n_results++;
        if (out_distance !== want.distance) begin
          flag_mismatch($sformatf("query %0d,%0d gave distance %0d, predicted %0d",
                                  want.node_a, want.node_b, out_distance, want.distance));
        end
        if (want.distance == DIST_NONE) n_unrelated++;
        else if (int'(want.distance) > max_dist) max_dist = want.distance;
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin : main_proc
    int size;
    bit mid_hold_done;
    mid_hold_done = 1'b0;
    foreach (parent_of[i]) parent_of[i] = '0;

    // Directed part: empty table, node zero, a small tree, loops and cleared links.
    plan_item(CMD_QUERY, 1, 1);
    plan_item(CMD_QUERY, 0, 5);
    plan_item(CMD_QUERY, 5, 0);
    plan_item(CMD_QUERY, 1, 2);
    plan_item(CMD_LINK, 0, 5);
    plan_item(CMD_LINK, 2, 1);
    plan_item(CMD_LINK, 3, 2);
    plan_item(CMD_LINK, 127, 1);
    plan_item(CMD_LINK, 64, 3);
    plan_item(CMD_QUERY, 64, 127);
    plan_item(CMD_QUERY, 127, 64);
    plan_item(CMD_QUERY, 1, 64);
    plan_item(CMD_QUERY, 64, 1);
    plan_item(CMD_LINK, 1, 127);
    plan_item(CMD_QUERY, 64, 127);
    plan_item(CMD_QUERY, 2, 3);
    plan_item(CMD_QUERY, 127, 127);
    plan_item(CMD_LINK, 1, 0);
    plan_item(CMD_QUERY, 64, 127);
    plan_item(CMD_LINK, 127, 127);
    plan_item(CMD_QUERY, 127, 5);
    plan_item(CMD_QUERY, 64, 127);
    plan_item(CMD_LINK, 64, 0);
    plan_item(CMD_QUERY, 64, 3);
    plan_item(CMD_LINK, 0, 0);

    // Random part: mostly well-formed forests with queries, some loose noise.
    plan_item(CMD_QUERY, $urandom_range(1, TABLE_N - 1), $urandom_range(1, TABLE_N - 1), 1'b1);
    while (n_planned < ITEMS) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(64, TABLE_N - 1)
                                         : $urandom_range(2, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: plan_forest(size, SHAPE_BUSHY, 1'b0);
        4, 5: plan_forest(size, SHAPE_FORK, 1'b0);
        6, 7: plan_forest(size, SHAPE_CHAIN, 1'b0);
        8: plan_forest(size, SHAPE_BUSHY, 1'b1);
        default: begin
          repeat ($urandom_range(5, 15)) begin
            plan_item(tkd_cmd_t'($urandom_range(0, 1)), $urandom_range(0, TABLE_N - 1),
                      $urandom_range(0, TABLE_N - 1));
          end
        end
      endcase
      if (!mid_hold_done && n_planned >= ITEMS / 2) begin
        plan_item(CMD_QUERY, $urandom_range(1, TABLE_N - 1), $urandom_range(1, TABLE_N - 1),
                  1'b1);
        mid_hold_done = 1'b1;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Checked mid-cycle, where the driver never touches the plan or start.
    while (pending_items.size() != 0 || start) @(negedge clk);
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (2 * TABLE_N + 16) @(posedge clk);

    $display("Covered %0d link and %0d query transactions, %0d sender drain pauses.",
             n_links, n_queries, n_holds);
    $display("Checked %0d distances: %0d unrelated pairs, longest distance %0d, %0d mismatches.",
             n_results, n_unrelated, max_dist, n_errors);
    if (n_errors == 0) begin
      $display("[tree_kinship_distance_core] OK");
    end else begin
      $display("[tree_kinship_distance_core] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake or a missing result.
  initial begin : watchdog_proc
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d transactions planned and %0d results outstanding.",
             pending_items.size(), expected_dist.size());
    $display("[tree_kinship_distance_core] ERROR");
    $finish;
  end

endmodule
